FILE: hw/rtl/psd_pkg.sv
// Shared types, constants and controller/datapath interface for the port scan detector.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int SOURCE_ENTRIES_DEF   = 64;
    localparam int PORTS_PER_SOURCE_DEF = 16;
    localparam int RULE_COUNT_DEF       = 6;

    localparam int NUM_RULE_WORDS = 6;
    localparam int RULE_W         = 19;
    localparam int THR_W          = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int RULE_IDX_W     = 3;
    localparam int PORT_W         = 16;
    localparam int ADDR_W         = 32;
    localparam int SEV_W          = 2;
    localparam int DPORTS_W       = 5;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 3'd6;

    localparam logic [ADDR_W-1:0] DNS_PRIMARY   = 32'h0808_0808;
    localparam logic [ADDR_W-1:0] DNS_SECONDARY = 32'h0808_0404;
    localparam logic [7:0]        MCAST_OCTET   = 8'd224;

    localparam logic ALERT_RULE = 1'b0;
    localparam logic ALERT_SCAN = 1'b1;

    localparam logic [SEV_W-1:0] SEV_HIGH    = 2'd2;
    localparam logic [SEV_W-1:0] SEV_INVALID = 2'd3;

    localparam int RULE_EN_BIT = 18;

    typedef logic [RULE_W-1:0] rule_word_t;
    typedef rule_word_t [NUM_RULE_WORDS-1:0] rule_bank_t;

    localparam rule_bank_t RULE_RESET = {
        19'd0, 19'd265450, 19'd396605, 19'd393661, 19'd327701, 19'd393239
    };
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRC_RD,
        ST_SRC_CMP,
        ST_ALLOC,
        ST_INFO_RD,
        ST_INFO_LD,
        ST_PORT_CHK,
        ST_PORT_RD,
        ST_PORT_CMP,
        ST_PORT_ADD,
        ST_RULE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic idx_inc;
        logic found;
        logic alloc;
        logic info_ld;
        logic k_inc;
        logic record;
        logic rule_inc;
        logic emit_rule;
        logic emit_scan;
        logic info_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic drop;
        logic in_use_zero;
        logic src_hit;
        logic idx_last;
        logic table_full;
        logic tracked;
        logic tally_zero;
        logic port_hit;
        logic k_last;
        logic tally_full;
        logic rule_match;
        logic rule_last;
        logic scan_hit;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/port_rule_and_scan_detector.sv
// Top level of the port rule and port scan detector.
`timescale 1ns / 1ps

// One packet header word is taken at a time; s_tready is high only while the
// block is idle. A dropped packet (DNS server source or destination octet 224)
// goes straight back to idle. For a kept packet the block searches the source
// table (up to SOURCE_ENTRIES entries, one table read and compare per entry),
// then, if the source is tracked, its stored ports (up to PORTS_PER_SOURCE,
// likewise), then the RULE_COUNT rules in order, stalling while an alert
// waits on m_tready. Alerts leave through a one-word output register, in rule
// order, with the scan alert last and tlast on the final alert of a packet.
// The tables need no clearing pass: a fill count marks the valid sources.
module port_rule_and_scan_detector #(
    parameter int SOURCE_ENTRIES   = psd_pkg::SOURCE_ENTRIES_DEF,
    parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_PER_SOURCE_DEF,
    parameter int RULE_COUNT       = psd_pkg::RULE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // source_address[31:0], dest_address[63:32], dest_port[79:64]
    input  logic [psd_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rule_index[2:0], severity[4:3], alert_source[36:5], alert_port[52:37],
    // distinct_ports[57:53], zero fill[63:58]
    output logic [psd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // alert_kind
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psd_pkg::RULE_W-1:0]       cfg_data
);

    psd_pkg::dp_cmd_t            cmd;
    psd_pkg::dp_status_t         status;
    psd_pkg::rule_bank_t         rules;
    logic [psd_pkg::THR_W-1:0]   threshold;

    psd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rules     (rules),
        .threshold (threshold)
    );

    psd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psd_datapath #(
        .SOURCE_ENTRIES   (SOURCE_ENTRIES),
        .PORTS_PER_SOURCE (PORTS_PER_SOURCE),
        .RULE_COUNT       (RULE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .rules     (rules),
        .threshold (threshold),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hw/rtl/psd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/psd_cfg_regs.sv
// Rule words and scan threshold registers with their write port.
`timescale 1ns / 1ps

module psd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::RULE_W-1:0]      cfg_data,
    output psd_pkg::rule_bank_t             rules,
    output logic [psd_pkg::THR_W-1:0]       threshold
);

    psd_pkg::rule_bank_t              rules_reg;
    logic [psd_pkg::THR_W-1:0]        threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_reg     <= psd_pkg::RULE_RESET;
            threshold_reg <= psd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < psd_pkg::CFG_IDX_W'(psd_pkg::NUM_RULE_WORDS))
            begin
                rules_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == psd_pkg::CFG_IDX_THRESHOLD)
            begin
                threshold_reg <= cfg_data[psd_pkg::THR_W-1:0];
            end
        end
    end

    assign rules     = rules_reg;
    assign threshold = threshold_reg;

endmodule

FILE: hw/rtl/psd_datapath.sv
// Datapath: packet latch, source and port tables, rule compare, alert output register.
`timescale 1ns / 1ps

module psd_datapath #(
    parameter int SOURCE_ENTRIES   = psd_pkg::SOURCE_ENTRIES_DEF,
    parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_PER_SOURCE_DEF,
    parameter int RULE_COUNT       = psd_pkg::RULE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psd_pkg::dp_cmd_t                  cmd,
    output psd_pkg::dp_status_t               status,
    input  logic [psd_pkg::IN_DATA_W-1:0]     s_tdata,
    input  psd_pkg::rule_bank_t               rules,
    input  logic [psd_pkg::THR_W-1:0]         threshold,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [psd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int IU_W  = $clog2(SOURCE_ENTRIES + 1);
    localparam int SE_AW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PORTS_PER_SOURCE + 1);
    localparam int SP_DEPTH = SOURCE_ENTRIES * PORTS_PER_SOURCE;
    localparam int SP_AW = (SP_DEPTH > 1) ? $clog2(SP_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > psd_pkg::THR_W) ? CNT_W : psd_pkg::THR_W;
    localparam int DP_W  = (CNT_W > psd_pkg::DPORTS_W) ? CNT_W : psd_pkg::DPORTS_W;
    localparam int INFO_W = CNT_W + 1;

    // latched packet
    logic [psd_pkg::ADDR_W-1:0] src_reg;
    logic [psd_pkg::ADDR_W-1:0] dst_reg;
    logic [psd_pkg::PORT_W-1:0] port_reg;

    logic [IU_W-1:0]               idx_reg;
    logic [IU_W-1:0]               in_use_reg;
    logic [SE_AW-1:0]              entry_reg;
    logic                          tracked_reg;
    logic [CNT_W-1:0]              tally_reg;
    logic                          reported_reg;
    logic [CNT_W-1:0]              k_reg;
    logic [psd_pkg::RULE_IDX_W-1:0] rule_reg;

    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [psd_pkg::RULE_IDX_W-1:0] out_idx_reg;
    logic [psd_pkg::SEV_W-1:0]      out_sev_reg;
    logic [psd_pkg::ADDR_W-1:0]     out_src_reg;
    logic [psd_pkg::PORT_W-1:0]     out_port_reg;
    logic [psd_pkg::DPORTS_W-1:0]   out_dports_reg;
    logic                           out_last_reg;

    logic [psd_pkg::ADDR_W-1:0] tracked_rdata;
    logic [INFO_W-1:0]          info_rdata;
    logic [INFO_W-1:0]          info_wdata;
    logic [psd_pkg::PORT_W-1:0] seen_rdata;
    logic [SP_AW-1:0]           seen_base;
    logic [SP_AW-1:0]           seen_raddr;
    logic [SP_AW-1:0]           seen_waddr;

    logic [psd_pkg::NUM_RULE_WORDS-1:0] match_mask;
    logic                               later_match;
    logic [psd_pkg::SEV_W-1:0]          rule_sev;
    logic [psd_pkg::THR_W-1:0]          thr_eff;
    logic                               scan_hit;
    logic                               out_free;
    logic [DP_W-1:0]                    tally_ext;

    // source address table
    psd_ram #(
        .WIDTH (psd_pkg::ADDR_W),
        .DEPTH (SOURCE_ENTRIES)
    ) u_tracked_ram (
        .clk   (clk),
        .we    (cmd.alloc),
        .waddr (in_use_reg[SE_AW-1:0]),
        .wdata (src_reg),
        .raddr (idx_reg[SE_AW-1:0]),
        .rdata (tracked_rdata)
    );

    // per-source {scan reported, port tally}
    psd_ram #(
        .WIDTH (INFO_W),
        .DEPTH (SOURCE_ENTRIES)
    ) u_info_ram (
        .clk   (clk),
        .we    (cmd.info_wr),
        .waddr (entry_reg),
        .wdata (info_wdata),
        .raddr (entry_reg),
        .rdata (info_rdata)
    );

    // distinct ports, PORTS_PER_SOURCE slots per source
    psd_ram #(
        .WIDTH (psd_pkg::PORT_W),
        .DEPTH (SP_DEPTH)
    ) u_seen_ram (
        .clk   (clk),
        .we    (cmd.record),
        .waddr (seen_waddr),
        .wdata (port_reg),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    assign seen_base  = SP_AW'(entry_reg) * SP_AW'(PORTS_PER_SOURCE);
    assign seen_raddr = seen_base + SP_AW'(k_reg);
    assign seen_waddr = seen_base + SP_AW'(tally_reg);

    assign thr_eff   = (threshold == '0) ? psd_pkg::THR_W'(1) : threshold;
    assign scan_hit  = tracked_reg && !reported_reg
                       && (CMP_W'(tally_reg) >= CMP_W'(thr_eff));
    assign info_wdata = {reported_reg | scan_hit, tally_reg};
    assign out_free  = !out_valid_reg || m_tready;
    assign tally_ext = DP_W'(tally_reg);

    always_comb
    begin
        match_mask  = '0;
        later_match = 1'b0;
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            match_mask[i] = rules[i][psd_pkg::RULE_EN_BIT]
                            && (rules[i][psd_pkg::PORT_W-1:0] == port_reg);
        end
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            if ((psd_pkg::RULE_IDX_W'(i) > rule_reg) && match_mask[i])
            begin
                later_match = 1'b1;
            end
        end
        rule_sev = rules[rule_reg][psd_pkg::PORT_W +: psd_pkg::SEV_W];
        if (rule_sev == psd_pkg::SEV_INVALID)
        begin
            rule_sev = psd_pkg::SEV_HIGH;
        end
    end

    always_comb
    begin
        status.drop        = (src_reg == psd_pkg::DNS_PRIMARY)
                             || (src_reg == psd_pkg::DNS_SECONDARY)
                             || (dst_reg[31:24] == psd_pkg::MCAST_OCTET);
        status.in_use_zero = (in_use_reg == '0);
        status.src_hit     = (tracked_rdata == src_reg);
        status.idx_last    = ((idx_reg + IU_W'(1)) == in_use_reg);
        status.table_full  = (in_use_reg == IU_W'(SOURCE_ENTRIES));
        status.tracked     = tracked_reg;
        status.tally_zero  = (tally_reg == '0);
        status.port_hit    = (seen_rdata == port_reg);
        status.k_last      = ((k_reg + CNT_W'(1)) == tally_reg);
        status.tally_full  = (tally_reg == CNT_W'(PORTS_PER_SOURCE));
        status.rule_match  = match_mask[rule_reg];
        status.rule_last   = (rule_reg == psd_pkg::RULE_IDX_W'(RULE_COUNT - 1));
        status.scan_hit    = scan_hit;
        status.out_free    = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            src_reg  <= s_tdata[31:0];
            dst_reg  <= s_tdata[63:32];
            port_reg <= s_tdata[79:64];
        end
        if (cmd.found)
        begin
            entry_reg <= idx_reg[SE_AW-1:0];
        end
        else if (cmd.alloc)
        begin
            entry_reg <= in_use_reg[SE_AW-1:0];
        end
        if (cmd.alloc)
        begin
            tally_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (cmd.info_ld)
        begin
            tally_reg    <= info_rdata[CNT_W-1:0];
            reported_reg <= info_rdata[CNT_W];
        end
        else if (cmd.record)
        begin
            tally_reg <= tally_reg + CNT_W'(1);
        end
        if (cmd.emit_rule)
        begin
            out_kind_reg   <= psd_pkg::ALERT_RULE;
            out_idx_reg    <= rule_reg;
            out_sev_reg    <= rule_sev;
            out_src_reg    <= src_reg;
            out_port_reg   <= port_reg;
            out_dports_reg <= '0;
            out_last_reg   <= !later_match && !scan_hit;
        end
        else if (cmd.emit_scan)
        begin
            out_kind_reg   <= psd_pkg::ALERT_SCAN;
            out_idx_reg    <= '0;
            out_sev_reg    <= psd_pkg::SEV_HIGH;
            out_src_reg    <= src_reg;
            out_port_reg   <= port_reg;
            out_dports_reg <= tally_ext[psd_pkg::DPORTS_W-1:0];
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            in_use_reg    <= '0;
            tracked_reg   <= 1'b0;
            k_reg         <= '0;
            rule_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                idx_reg     <= '0;
                k_reg       <= '0;
                rule_reg    <= '0;
                tracked_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + IU_W'(1);
                end
                if (cmd.k_inc)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                if (cmd.rule_inc)
                begin
                    rule_reg <= rule_reg + psd_pkg::RULE_IDX_W'(1);
                end
                if (cmd.found || cmd.alloc)
                begin
                    tracked_reg <= 1'b1;
                end
            end
            if (cmd.alloc)
            begin
                in_use_reg <= in_use_reg + IU_W'(1);
            end
            if (cmd.emit_rule || cmd.emit_scan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_dports_reg, out_port_reg, out_src_reg,
                       out_sev_reg, out_idx_reg};

endmodule

FILE: hw/rtl/psd_ctrl.sv
// Controller: per-packet sequencing of source search, port record and alert emission.
`timescale 1ns / 1ps

module psd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  psd_pkg::dp_status_t status,
    output psd_pkg::dp_cmd_t    cmd
);

    psd_pkg::state_t state_reg;
    psd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            psd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = psd_pkg::ST_CHECK;
                end
            end
            psd_pkg::ST_CHECK:
            begin
                priority if (status.drop)
                    state_next = psd_pkg::ST_IDLE;
                else if (status.in_use_zero)
                    state_next = psd_pkg::ST_ALLOC;
                else
                    state_next = psd_pkg::ST_SRC_RD;
            end
            psd_pkg::ST_SRC_RD:
            begin
                state_next = psd_pkg::ST_SRC_CMP;
            end
            psd_pkg::ST_SRC_CMP:
            begin
                priority if (status.src_hit)
                begin
                    cmd.found  = 1'b1;
                    state_next = psd_pkg::ST_INFO_RD;
                end
                else if (status.idx_last)
                begin
                    state_next = psd_pkg::ST_ALLOC;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = psd_pkg::ST_SRC_RD;
                end
            end
            psd_pkg::ST_ALLOC:
            begin
                // full table: source stays untracked, rules still apply
                if (status.table_full)
                begin
                    state_next = psd_pkg::ST_RULE;
                end
                else
                begin
                    cmd.alloc  = 1'b1;
                    state_next = psd_pkg::ST_PORT_CHK;
                end
            end
            psd_pkg::ST_INFO_RD:
            begin
                state_next = psd_pkg::ST_INFO_LD;
            end
            psd_pkg::ST_INFO_LD:
            begin
                cmd.info_ld = 1'b1;
                state_next  = psd_pkg::ST_PORT_CHK;
            end
            psd_pkg::ST_PORT_CHK:
            begin
                state_next = status.tally_zero ? psd_pkg::ST_PORT_ADD : psd_pkg::ST_PORT_RD;
            end
            psd_pkg::ST_PORT_RD:
            begin
                state_next = psd_pkg::ST_PORT_CMP;
            end
            psd_pkg::ST_PORT_CMP:
            begin
                priority if (status.port_hit)
                begin
                    state_next = psd_pkg::ST_RULE;
                end
                else if (status.k_last)
                begin
                    state_next = psd_pkg::ST_PORT_ADD;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = psd_pkg::ST_PORT_RD;
                end
            end
            psd_pkg::ST_PORT_ADD:
            begin
                cmd.record = !status.tally_full;
                state_next = psd_pkg::ST_RULE;
            end
            psd_pkg::ST_RULE:
            begin
                if (!status.rule_match || status.out_free)
                begin
                    cmd.emit_rule = status.rule_match;
                    if (status.rule_last)
                    begin
                        state_next = psd_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cmd.rule_inc = 1'b1;
                    end
                end
            end
            psd_pkg::ST_SCAN:
            begin
                priority if (!status.tracked)
                begin
                    state_next = psd_pkg::ST_IDLE;
                end
                else if (!status.scan_hit || status.out_free)
                begin
                    // write back tally and the reported flag together
                    cmd.emit_scan = status.scan_hit;
                    cmd.info_wr   = 1'b1;
                    state_next    = psd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = psd_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = psd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
